[src/hmtp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hmtp_pkg;

    // Parser modes, one-hot.
    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_NUM    = 4'b0010,
        MODE_PREFIX = 4'b0100,
        MODE_HEX    = 4'b1000
    } t_mode;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAP_WIDTH     = 2'd0;
    localparam logic [1:0] REG_MAP_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_DEFAULT_COLOR = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 13;

    // Register reset values.
    localparam logic [DIM_W-1:0] DIM_RESET   = 13'd1;
    localparam logic [31:0]      COLOR_RESET = 32'hFFFF_FFFF;

    // Largest height magnitude before negation.
    localparam logic [31:0] MAG_MAX = 32'h7FFF_FFFF;

    // Characters the parser reacts to.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;

    // Number of characters skipped after the comma (the "0x").
    localparam logic [1:0] PREFIX_LEN = 2'd2;

    // One finished point as handed from the parser to the placement stage.
    typedef struct packed {
        logic signed [31:0] height;
        logic [31:0]        color;
    } t_point;

endpackage

`default_nettype wire

[src/hmtp_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module hmtp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [7:0]     i_char_in,
    input  wire logic           i_end_of_text,
    input  wire logic [31:0]    i_default_color,
    output logic                o_point_valid,
    output hmtp_pkg::t_point    o_point
);
    import hmtp_pkg::*;

    t_mode       r_mode, n_mode;
    logic        r_neg, n_neg;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_color, n_color;
    logic [1:0]  r_skip, n_skip;

    logic        emit;
    logic [31:0] emit_mag;
    logic        emit_neg;
    logic [31:0] emit_color;
    logic        start_idle;
    logic [7:0]  idle_c;
    logic        c_digit;
    logic        c_space;
    logic        c_hex;
    logic [3:0]  c_hexval;
    logic [34:0] acc_x10;

    // Character classes.
    always_comb begin
        c_digit  = (i_char_in >= CH_0) && (i_char_in <= CH_9);
        c_space  = (i_char_in == CH_SPACE) || ((i_char_in >= CH_TAB) && (i_char_in <= CH_CR));
        c_hex    = 1'b1;
        c_hexval = 4'd0;
        if (c_digit) begin
            c_hexval = 4'(i_char_in - CH_0);
        end else if ((i_char_in >= CH_LA) && (i_char_in <= CH_LF)) begin
            c_hexval = 4'(i_char_in - CH_LA + 8'd10);
        end else if ((i_char_in >= CH_UA) && (i_char_in <= CH_UF)) begin
            c_hexval = 4'(i_char_in - CH_UA + 8'd10);
        end else begin
            c_hex = 1'b0;
        end
        acc_x10 = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1)
                  + {31'd0, 4'(i_char_in - CH_0)};
    end

    // Next parser state for one character, then the end-of-text flush.
    always_comb begin
        n_mode     = r_mode;
        n_neg      = r_neg;
        n_acc      = r_acc;
        n_color    = r_color;
        n_skip     = r_skip;
        emit       = 1'b0;
        emit_mag   = r_acc;
        emit_neg   = r_neg;
        emit_color = i_default_color;
        start_idle = 1'b0;
        idle_c     = i_char_in;

        case (r_mode)
            MODE_NUM: begin
                if (c_digit) begin
                    n_acc = (acc_x10 > {3'b000, MAG_MAX}) ? MAG_MAX : acc_x10[31:0];
                end else if (i_char_in == CH_COMMA) begin
                    n_mode  = MODE_PREFIX;
                    n_skip  = PREFIX_LEN;
                    n_color = '0;
                end else begin
                    emit       = 1'b1;
                    start_idle = 1'b1;
                end
            end
            MODE_PREFIX: begin
                n_skip = r_skip - 2'd1;
                if (n_skip == 2'd0) begin
                    n_mode = MODE_HEX;
                end
            end
            MODE_HEX: begin
                if (c_hex) begin
                    n_color = {r_color[27:0], c_hexval};
                end else begin
                    emit       = 1'b1;
                    emit_color = r_color;
                    start_idle = 1'b1;
                end
            end
            default: begin
                start_idle = 1'b1;
                if (c_space) begin
                    idle_c = 8'd0;
                end
            end
        endcase

        // A character outside a number may open a new one.
        if (start_idle) begin
            n_mode  = MODE_IDLE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_color = '0;
            n_skip  = '0;
            if ((idle_c == CH_MINUS) || (idle_c == CH_PLUS)) begin
                n_mode = MODE_NUM;
                n_neg  = (idle_c == CH_MINUS);
            end else if ((idle_c >= CH_0) && (idle_c <= CH_9)) begin
                n_mode = MODE_NUM;
                n_acc  = {24'd0, idle_c - CH_0};
            end
        end

        // End of text flushes a pending number and returns to idle.
        if (i_end_of_text) begin
            if (!emit && (n_mode != MODE_IDLE)) begin
                emit       = 1'b1;
                emit_mag   = n_acc;
                emit_neg   = n_neg;
                emit_color = (n_mode == MODE_NUM) ? i_default_color : n_color;
            end
            n_mode  = MODE_IDLE;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_color = '0;
            n_skip  = '0;
        end
    end

    // The height is stored negated: a minus sign gives a positive value.
    assign o_point_valid = i_accept && emit;
    assign o_point.height = emit_neg ? signed'(emit_mag) : signed'(32'd0 - emit_mag);
    assign o_point.color  = emit_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
            r_color <= '0;
            r_skip  <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
            r_color <= n_color;
            r_skip  <= n_skip;
        end
    end

endmodule

`default_nettype wire

[src/hmtp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module hmtp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire hmtp_pkg::t_point i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output hmtp_pkg::t_point    o_data
);
    import hmtp_pkg::*;

    t_point     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Two-entry point buffer between parser and placement.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

[src/hmtp_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module hmtp_back #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [hmtp_pkg::DIM_W-1:0] i_map_width,
    input  wire logic [hmtp_pkg::DIM_W-1:0] i_map_height,
    input  wire logic                       i_pt_valid,
    input  wire hmtp_pkg::t_point           i_pt,
    output logic                            o_pt_pop,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic signed [hmtp_pkg::POS_W-1:0] o_row_pos,
    output logic signed [hmtp_pkg::POS_W-1:0] o_col_pos,
    output logic signed [31:0]              o_height_val,
    output logic [31:0]                     o_point_color,
    output logic                            o_last_point
);
    import hmtp_pkg::*;

    localparam int CW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;

    logic [CW-1:0]          r_row;
    logic [CW-1:0]          r_col;
    logic                   r_done;
    logic                   r_out_valid;
    logic signed [POS_W-1:0] r_row_pos;
    logic signed [POS_W-1:0] r_col_pos;
    logic signed [31:0]     r_height;
    logic [31:0]            r_color;
    logic                   r_last;

    logic [DIM_W-1:0] w_dim;
    logic [DIM_W-1:0] h_dim;
    logic             load_ok;
    logic             place;
    logic             col_wrap;
    logic             row_wrap;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if ({{(32-DIM_W){1'b0}}, v} > 32'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    assign w_dim = clamp_dim(i_map_width);
    assign h_dim = clamp_dim(i_map_height);

    // Points after the last one are drained and dropped.
    assign load_ok  = !r_out_valid || i_pop;
    assign o_pt_pop = i_pt_valid && (r_done || load_ok);
    assign place    = o_pt_pop && !r_done;

    assign col_wrap = (32'(r_col) + 32'd1) >= {{(32-DIM_W){1'b0}}, w_dim};
    assign row_wrap = (32'(r_row) + 32'd1) >= {{(32-DIM_W){1'b0}}, h_dim};

    // Row-major position counters and the map-done flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (place) begin
                r_out_valid <= 1'b1;
                if (col_wrap) begin
                    r_col <= '0;
                    if (row_wrap) begin
                        r_row  <= '0;
                        r_done <= 1'b1;
                    end else begin
                        r_row <= r_row + CW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register, centered on the map.
    always_ff @(posedge i_clk) begin
        if (place) begin
            r_row_pos <= signed'(POS_W'(32'(r_row) - 32'(h_dim >> 1)));
            r_col_pos <= signed'(POS_W'(32'(r_col) - 32'(w_dim >> 1)));
            r_height  <= i_pt.height;
            r_color   <= i_pt.color;
            r_last    <= col_wrap && row_wrap;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_row_pos     = r_row_pos;
    assign o_col_pos     = r_col_pos;
    assign o_height_val  = r_height;
    assign o_point_color = r_color;
    assign o_last_point  = r_last;

endmodule

`default_nettype wire

[src/heightmap_text_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake          Payload
// input     i_push / o_full    i_char_in, i_end_of_text
// result    o_empty / i_pop    o_row_pos, o_col_pos, o_height_val, o_point_color, o_last_point
// config    i_cfg_we           i_cfg_index, i_cfg_data
//
// One character per cycle; the parser takes a character whenever its two-entry point
// buffer is not full, and a point passes through that buffer before it is placed in the
// result register.
// Reset (i_rst_n low at a clock edge) clears the parser, the buffer and the position
// counters, and loads the configuration registers with their default values.
// A stalled result side fills the point buffer, which then raises o_full; after the
// last point of the map all further points are dropped until reset.

module heightmap_text_parser_core #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    output logic                                  o_full,
    input  wire logic [7:0]                       i_char_in,
    input  wire logic                             i_end_of_text,
    output logic                                  o_empty,
    input  wire logic                             i_pop,
    output logic signed [hmtp_pkg::POS_W-1:0]     o_row_pos,
    output logic signed [hmtp_pkg::POS_W-1:0]     o_col_pos,
    output logic signed [31:0]                    o_height_val,
    output logic [31:0]                           o_point_color,
    output logic                                  o_last_point,
    input  wire logic                             i_cfg_we,
    input  wire logic [hmtp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [hmtp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import hmtp_pkg::*;

    logic [DIM_W-1:0] r_map_width;
    logic [DIM_W-1:0] r_map_height;
    logic [31:0]      r_default_color;

    logic   accept;
    logic   pt_push;
    t_point pt_in;
    logic   q_valid;
    logic   q_pop;
    t_point q_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width     <= DIM_RESET;
            r_map_height    <= DIM_RESET;
            r_default_color <= COLOR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:     r_map_width     <= i_cfg_data[DIM_W-1:0];
                REG_MAP_HEIGHT:    r_map_height    <= i_cfg_data[DIM_W-1:0];
                REG_DEFAULT_COLOR: r_default_color <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign accept = i_push && !o_full;

    hmtp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_char_in       (i_char_in),
        .i_end_of_text   (i_end_of_text),
        .i_default_color (r_default_color),
        .o_point_valid   (pt_push),
        .o_point         (pt_in)
    );

    hmtp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pt_push),
        .i_data  (pt_in),
        .o_full  (o_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    hmtp_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_map_width   (r_map_width),
        .i_map_height  (r_map_height),
        .i_pt_valid    (q_valid),
        .i_pt          (q_data),
        .o_pt_pop      (q_pop),
        .o_empty       (o_empty),
        .i_pop         (i_pop),
        .o_row_pos     (o_row_pos),
        .o_col_pos     (o_col_pos),
        .o_height_val  (o_height_val),
        .o_point_color (o_point_color),
        .o_last_point  (o_last_point)
    );

    // Once the last point is taken, no further result ever appears.
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && o_last_point) |=> o_empty)
        else $error("result after last point");

    // A full buffer always has a point for the placement stage.
    a_full_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> q_valid)
        else $error("buffer full without data");

    // Saturation keeps the height inside the symmetric 32-bit range.
    a_height_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_height_val != 32'sh8000_0000))
        else $error("height out of range");

endmodule

`default_nettype wire

[verif/hmtp_point_checker.sv]
`timescale 1ns / 1ps

// Watches the character and point channels of the height-map parser, predicts
// every point from the accepted characters and compares each accepted point
// with the oldest prediction.
module hmtp_point_checker #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic        i_full,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_end_of_text,
    input  wire logic        i_empty,
    input  wire logic        i_pop,
    input  wire logic [12:0] i_row_pos,
    input  wire logic [12:0] i_col_pos,
    input  wire logic [31:0] i_height_val,
    input  wire logic [31:0] i_point_color,
    input  wire logic        i_last_point,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_error_count,
    output int               o_points_pending
);

    import hmtp_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] row_pos;
        logic [POS_W-1:0] col_pos;
        logic [31:0]      height_val;
        logic [31:0]      point_color;
        logic             last_point;
    } t_map_point;

    t_map_point expected_points [$];

    // Shadow copy of the configuration registers.
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic [31:0]      cfg_color;

    // Parser state as the block should hold it.
    t_mode       mode;
    logic        neg;
    logic [31:0] magnitude;
    logic [31:0] color_acc;
    logic [1:0]  skip_left;
    int          row_idx;
    int          col_idx;
    logic        map_complete;
    int          errors = 0;

    // Sizes of zero count as one, sizes above the maximum as the maximum.
    function automatic int dim_used(input logic [DIM_W-1:0] v);
        if (v == '0) return 1;
        if (int'(v) > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (is_digit(c)) return int'(c - CH_0);
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        return -1;
    endfunction

    // The magnitude saturates instead of wrapping.
    function automatic void take_digit(input logic [3:0] d);
        if (magnitude > (MAG_MAX - 32'(d)) / 32'd10) magnitude = MAG_MAX;
        else magnitude = magnitude * 32'd10 + 32'(d);
    endfunction

    // A character seen with no number open: a sign or a digit starts one.
    function automatic void open_token(input logic [7:0] c);
        mode = MODE_IDLE;
        magnitude = '0;
        neg = 1'b0;
        color_acc = '0;
        skip_left = '0;
        if (c == CH_MINUS || c == CH_PLUS) begin
            mode = MODE_NUM;
            neg = (c == CH_MINUS);
        end else if (is_digit(c)) begin
            mode = MODE_NUM;
            magnitude = 32'(c - CH_0);
        end
    endfunction

    // Predict one point and advance the row-major position.
    function automatic void emit_point(input logic [31:0] color);
        t_map_point p;
        int w;
        int h;
        w = dim_used(cfg_width);
        h = dim_used(cfg_height);
        p.row_pos = POS_W'(row_idx - h / 2);
        p.col_pos = POS_W'(col_idx - w / 2);
        p.height_val = neg ? magnitude : 32'd0 - magnitude;
        p.point_color = color;
        p.last_point = 1'b0;
        col_idx++;
        if (col_idx >= w) begin
            col_idx = 0;
            row_idx++;
            if (row_idx >= h) begin
                row_idx = 0;
                map_complete = 1'b1;
                p.last_point = 1'b1;
            end
        end
        expected_points.push_back(p);
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic eot);
        bit made;
        int hv;
        made = 1'b0;
        if (map_complete) return;
        case (mode)
            MODE_NUM: begin
                if (is_digit(c)) begin
                    take_digit(4'(c - CH_0));
                end else if (c == CH_COMMA) begin
                    mode = MODE_PREFIX;
                    skip_left = PREFIX_LEN;
                    color_acc = '0;
                end else begin
                    emit_point(cfg_color);
                    made = 1'b1;
                    open_token(c);
                end
            end
            MODE_PREFIX: begin
                skip_left = skip_left - 2'd1;
                if (skip_left == '0) mode = MODE_HEX;
            end
            MODE_HEX: begin
                hv = hex_digit(c);
                if (hv >= 0) begin
                    color_acc = {color_acc[27:0], 4'(hv)};
                end else begin
                    emit_point(color_acc);
                    made = 1'b1;
                    open_token(c);
                end
            end
            default: begin
                open_token(is_blank(c) ? 8'd0 : c);
            end
        endcase
        // End of text flushes a number still open, unless this character already made a point.
        if (eot) begin
            if (!made && mode != MODE_IDLE && !map_complete)
                emit_point(mode == MODE_NUM ? cfg_color : color_acc);
            open_token(8'd0);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [31:0] exp_v,
                                          input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic void check_point();
        t_map_point p;
        if (expected_points.size() == 0) begin
            $error("unexpected point: row 0x%0h col 0x%0h height 0x%0h color 0x%0h",
                   i_row_pos, i_col_pos, i_height_val, i_point_color);
            errors++;
            return;
        end
        p = expected_points.pop_front();
        compare_field("row_pos", 32'(p.row_pos), 32'(i_row_pos));
        compare_field("col_pos", 32'(p.col_pos), 32'(i_col_pos));
        compare_field("height_val", p.height_val, i_height_val);
        compare_field("point_color", p.point_color, i_point_color);
        compare_field("last_point", 32'(p.last_point), 32'(i_last_point));
    endfunction

    // Results are checked before the same edge's character is predicted, since a
    // point never leaves in the cycle its character arrives.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width = DIM_RESET;
            cfg_height = DIM_RESET;
            cfg_color = COLOR_RESET;
            row_idx = 0;
            col_idx = 0;
            map_complete = 1'b0;
            open_token(8'd0);
            expected_points.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MAP_WIDTH:     cfg_width = i_cfg_data[DIM_W-1:0];
                    REG_MAP_HEIGHT:    cfg_height = i_cfg_data[DIM_W-1:0];
                    REG_DEFAULT_COLOR: cfg_color = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) check_point();
            if (i_push && !i_full) parse_char(i_char_in, i_end_of_text);
        end
        o_points_pending <= expected_points.size();
        o_error_count <= errors;
    end

endmodule

[verif/heightmap_text_parser_core_tb.sv]
`timescale 1ns / 1ps

module heightmap_text_parser_core_tb;

    import hmtp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 3;
    localparam int MAP_MAX_DIM  = 4096;
    localparam int MAX_GAP      = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT  = 3000;
    localparam int SIDE_SEND    = 0;
    localparam int SIDE_RECV    = 1;

    // Index with no register behind it; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_push = 1'b0;
    logic                        o_full;
    logic [7:0]                  i_char_in = '0;
    logic                        i_end_of_text = 1'b0;
    logic                        o_empty;
    logic                        i_pop = 1'b0;
    logic signed [POS_W-1:0]     o_row_pos;
    logic signed [POS_W-1:0]     o_col_pos;
    logic signed [31:0]          o_height_val;
    logic [31:0]                 o_point_color;
    logic                        o_last_point;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    int         n_errors;
    int         n_pending;
    int         stall_cycles = 0;
    bit         hold_results = 1'b0;
    int         idle_left [2];
    bit         idle_off [2];
    logic [7:0] text_q [$];

    heightmap_text_parser_core #(
        .MAX_DIM(MAP_MAX_DIM)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(i_push),
        .o_full(o_full),
        .i_char_in(i_char_in),
        .i_end_of_text(i_end_of_text),
        .o_empty(o_empty),
        .i_pop(i_pop),
        .o_row_pos(o_row_pos),
        .o_col_pos(o_col_pos),
        .o_height_val(o_height_val),
        .o_point_color(o_point_color),
        .o_last_point(o_last_point),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    hmtp_point_checker #(
        .MAX_DIM(MAP_MAX_DIM)
    ) point_check (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(i_push),
        .i_full(o_full),
        .i_char_in(i_char_in),
        .i_end_of_text(i_end_of_text),
        .i_empty(o_empty),
        .i_pop(i_pop),
        .i_row_pos(o_row_pos),
        .i_col_pos(o_col_pos),
        .i_height_val(o_height_val),
        .i_point_color(o_point_color),
        .i_last_point(o_last_point),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_error_count(n_errors),
        .o_points_pending(n_pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle gaps come in stretches: some stretches never idle, the others draw 0 to MAX_GAP.
    function automatic int next_gap(input int side);
        if (idle_left[side] == 0) begin
            idle_left[side] = $urandom_range(8, 60);
            idle_off[side] = ($urandom_range(0, 2) == 0);
        end
        idle_left[side]--;
        if (idle_off[side]) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one character and wait for its transaction.
    task automatic send_char(input logic [7:0] ch, input logic eot);
        int gap;
        gap = next_gap(SIDE_SEND);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_char_in <= ch;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_full);
    endtask

    task automatic send_text(input string s, input bit eot_on_last);
        int i;
        for (i = 0; i < s.len(); i++)
            send_char(s[i], eot_on_last && (i == s.len() - 1));
    endtask

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(CH_0 + v);
        if ($urandom_range(0, 1) == 1) return 8'(CH_LA + v - 10);
        return 8'(CH_UA + v - 10);
    endfunction

    // Mostly signed numbers with optional color suffixes, mixed with blanks and noise.
    function automatic void add_token();
        int kind;
        int r;
        int n;
        int i;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 30) begin
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++) text_q.push_back(BLANKS[$urandom_range(0, 5)]);
        end else begin
            r = $urandom_range(0, 5);
            if (r < 2) text_q.push_back(CH_MINUS);
            else if (r == 2) text_q.push_back(CH_PLUS);
            // Digit count: sometimes none (a lone sign), sometimes enough to saturate.
            r = $urandom_range(0, 19);
            if (r == 0) n = 0;
            else if (r == 1) n = $urandom_range(10, 12);
            else n = $urandom_range(1, 4);
            if (r == 2) begin
                add_text(($urandom_range(0, 1) == 1) ? "2147483647" : "2147483648");
                n = 0;
            end
            for (i = 0; i < n; i++) text_q.push_back(8'(CH_0 + $urandom_range(0, 9)));
            // Color suffix, sometimes with an odd prefix or no hex digits at all.
            if ($urandom_range(0, 99) < 35) begin
                text_q.push_back(CH_COMMA);
                if ($urandom_range(0, 4) != 0) begin
                    add_text("0x");
                end else begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
                n = $urandom_range(0, 10);
                for (i = 0; i < n; i++) text_q.push_back(hex_char($urandom_range(0, 15)));
            end
            r = $urandom_range(0, 9);
            if (r < 6) text_q.push_back(BLANKS[$urandom_range(0, 5)]);
            else if (r == 6) text_q.push_back(($urandom_range(0, 1) == 1) ? CH_MINUS : CH_PLUS);
            else if (r == 7) text_q.push_back(8'($urandom_range(8'h3A, 8'h40)));
        end
    endfunction

    // Random text; the last character always ends the text so the parser goes idle.
    task automatic send_random_text(input int n_chars);
        int sent;
        logic [7:0] ch;
        sent = 0;
        while (sent < n_chars) begin
            if (text_q.size() == 0) add_token();
            ch = text_q.pop_front();
            sent++;
            send_char(ch, (sent == n_chars) || ($urandom_range(0, 49) == 0));
        end
        text_q.delete();
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Size writes carry random upper bits that the registers must drop.
    task automatic set_map(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic [31:0] color);
        write_reg(REG_MAP_WIDTH, ($urandom() & 32'hFFFF_E000) | 32'(w));
        write_reg(REG_MAP_HEIGHT, ($urandom() & 32'hFFFF_E000) | 32'(h));
        write_reg(REG_DEFAULT_COLOR, color);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_results();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: random pops, plus one long hold-off on request.
    initial begin : point_sink
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                i_pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                gap = next_gap(SIDE_RECV);
                if (gap > 0) begin
                    i_pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            i_pop <= 1'b1;
            do @(posedge i_clk); while (o_empty);
        end
    end

    // Watchdog: too long without any transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : char_source
        int p;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Oversized map so the directed text cannot finish it.
        write_reg(REG_SPARE, $urandom());
        set_map(13'h1FFF, 13'h1FFF, 32'h0000_0000);

        // Saturated negative height with a color, sign inside a number, lone sign,
        // the blanks 0x09 and 0x0B to 0x0D, stray bytes at both extremes, and end of text on an empty color.
        send_text("-9999999999,0xfA+3-\t", 1'b0);
        send_char(8'h0B, 1'b0);
        send_char(8'h0C, 1'b0);
        send_char(8'h0D, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("7,0x", 1'b1);
        send_random_text(150);
        drain_results();

        set_map(13'd4096, 13'd4096, 32'hFFFF_FFFF);
        send_random_text(200);
        drain_results();

        // Zero width counts as one column.
        set_map(13'd0, 13'd4096, $urandom());
        send_random_text(200);
        drain_results();

        set_map(13'd1, 13'($urandom_range(2048, 8191)), $urandom());
        send_random_text(200);

        // Narrow maps; one phase holds the point side back until the input stalls.
        for (p = 0; p < 5; p++) begin
            drain_results();
            set_map(13'($urandom_range(2, 12)), 13'($urandom_range(1024, 8191)), $urandom());
            if (p == 1) hold_results = 1'b1;
            send_random_text(200);
        end
        drain_results();

        // Shrink to one row so the map completes within a few points; later text is ignored.
        set_map(13'd3, 13'd0, $urandom());
        send_text("1 2 3 4 5 ", 1'b1);
        send_random_text(40);
        drain_results();

        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
